// ===== design/rv64i_execute_core_assert.svh =====
// Assertion macros for the RV64I execute core.
// Used by the top level; expects signals clk and rst in scope.
`ifndef RV64I_EXECUTE_CORE_ASSERT_SVH
`define RV64I_EXECUTE_CORE_ASSERT_SVH

// property must hold at every clock edge outside reset
`define RV64EX_ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define RV64EX_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== design/rv64ex_pkg.sv =====
// Shared types, constants and ALU functions for the RV64I execute core.
// No dependencies.
package rv64ex_pkg;

  localparam logic [31:0] HALT_WORD = 32'hfeedfeed;
  localparam logic [31:0] NOP_WORD  = 32'h00000013;
  localparam logic [63:0] TRAP_VECTOR_RESET = 64'h0000_0000_0000_8000;

  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP32   = 7'h3b;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OPIMM32 = 7'h1b;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [5:0] TOP6_BASE = 6'h00;
  localparam logic [5:0] TOP6_SRA  = 6'h10;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  typedef struct packed {
    logic        active;
    logic        is_load;
    logic [4:0]  dest;
    logic [2:0]  kind;
    logic [63:0] npc;
  } pend_t;

  typedef struct packed {
    logic [63:0] next_pc;
    logic [1:0]  mem_request;
    logic [63:0] mem_address;
    logic [63:0] store_data;
    logic [1:0]  access_size;
    logic        trap;
    logic        halted;
    logic        reg_written;
    logic [4:0]  write_index;
    logic [63:0] write_value;
  } result_t;

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] alu(input logic [2:0] f3, input logic alt,
                                      input logic [63:0] a, input logic [63:0] b);
    logic [5:0] sh;
    sh = b[5:0];
    case (f3)
      3'd0: return alt ? a - b : a + b;
      3'd1: return a << sh;
      3'd2: return {63'd0, $signed(a) < $signed(b)};
      3'd3: return {63'd0, a < b};
      3'd4: return a ^ b;
      3'd5: return alt ? 64'($signed(a) >>> sh) : a >> sh;
      3'd6: return a | b;
      default: return a & b;
    endcase
  endfunction

  function automatic logic [63:0] alu_w(input logic [2:0] f3, input logic alt,
                                        input logic [63:0] a, input logic [63:0] b);
    logic [31:0] lo;
    logic [4:0]  sh;
    logic [31:0] r;
    lo = a[31:0];
    sh = b[4:0];
    case (f3)
      3'd0: r = alt ? lo - b[31:0] : lo + b[31:0];
      3'd1: r = lo << sh;
      default: r = alt ? 32'($signed(lo) >>> sh) : lo >> sh;
    endcase
    return sext32(r);
  endfunction

  // kind is the load funct3: low bits give the size, bit 2 means unsigned
  function automatic logic [63:0] load_ext(input logic [2:0] kind, input logic [63:0] d);
    case (kind[1:0])
      2'd0: return kind[2] ? {56'd0, d[7:0]}  : {{56{d[7]}}, d[7:0]};
      2'd1: return kind[2] ? {48'd0, d[15:0]} : {{48{d[15]}}, d[15:0]};
      2'd2: return kind[2] ? {32'd0, d[31:0]} : {{32{d[31]}}, d[31:0]};
      default: return d;
    endcase
  endfunction

endpackage

// ===== design/rv64ex_regfile.sv =====
// 32 x 64 register file with registered reads, write bypass and valid bits.
// Depends on nothing; entries never written read as zero.
module rv64ex_regfile (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic [4:0]  ra1,
  input  logic [4:0]  ra2,
  output logic [63:0] rdata1,
  output logic [63:0] rdata2,
  input  logic        we,
  input  logic [4:0]  wa,
  input  logic [63:0] wd
);

  logic [63:0] mem [32];
  logic [31:0] vld;
  logic [63:0] d1, d2;
  logic        v1, v2;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      d1 <= (we && wa == ra1) ? wd : mem[ra1];
      d2 <= (we && wa == ra2) ? wd : mem[ra2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      v1  <= 1'b0;
      v2  <= 1'b0;
    end else begin
      if (we) begin
        vld[wa] <= 1'b1;
      end
      if (rd_en) begin
        v1 <= (we && wa == ra1) || vld[ra1];
        v2 <= (we && wa == ra2) || vld[ra2];
      end
    end
  end

  assign rdata1 = v1 ? d1 : 64'd0;
  assign rdata2 = v2 ? d2 : 64'd0;

endmodule

// ===== design/rv64ex_exec.sv =====
// Decode, legality check and execute for one item; purely combinational.
// Depends on rv64ex_pkg.
module rv64ex_exec (
  input  logic               operation,
  input  logic [31:0]        instruction_word,
  input  logic [63:0]        instruction_pc,
  input  logic               fetch_fault,
  input  logic [63:0]        load_data,
  input  logic               access_fault,
  input  logic [63:0]        a,
  input  logic [63:0]        b,
  input  logic [63:0]        trap_vector,
  input  rv64ex_pkg::pend_t  pend,
  output rv64ex_pkg::pend_t  pend_next,
  output rv64ex_pkg::result_t res
);

  logic [31:0] w;
  logic [6:0]  opc, f7;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [5:0]  top6;
  logic [63:0] pc4, imm_i, imm_s, imm_b, imm_j, imm_u, op2, val, npc;
  logic        legal, wr, take;

  assign w     = instruction_word;
  assign opc   = w[6:0];
  assign rd    = w[11:7];
  assign f3    = w[14:12];
  assign f7    = w[31:25];
  assign top6  = w[31:26];
  assign pc4   = instruction_pc + 64'd4;
  assign imm_i = {{52{w[31]}}, w[31:20]};
  assign imm_s = {{52{w[31]}}, w[31:25], w[11:7]};
  assign imm_b = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_j = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign imm_u = rv64ex_pkg::sext32({w[31:12], 12'd0});

  always_comb begin
    res       = '0;
    pend_next = pend;
    legal     = 1'b1;
    wr        = 1'b0;
    take      = 1'b0;
    val       = '0;
    op2       = '0;
    npc       = pc4;
    if (operation) begin
      if (pend.active) begin
        pend_next.active = 1'b0;
        if (access_fault) begin
          res.next_pc = trap_vector;
          res.trap    = 1'b1;
        end else begin
          res.next_pc = pend.npc;
          if (pend.is_load && pend.dest != 5'd0) begin
            res.reg_written = 1'b1;
            res.write_index = pend.dest;
            res.write_value = rv64ex_pkg::load_ext(pend.kind, load_data);
          end
        end
      end
    end else begin
      pend_next.active = 1'b0;
      if (fetch_fault) begin
        res.next_pc = trap_vector;
        res.trap    = 1'b1;
      end else if (w == rv64ex_pkg::HALT_WORD) begin
        res.next_pc = pc4;
        res.halted  = 1'b1;
      end else if (w == rv64ex_pkg::NOP_WORD) begin
        res.next_pc = pc4;
      end else begin
        case (opc)
          rv64ex_pkg::OPC_OP: begin
            if (f3 == 3'd0 || f3 == 3'd5) begin
              legal = f7 == rv64ex_pkg::F7_BASE || f7 == rv64ex_pkg::F7_ALT;
            end else begin
              legal = f7 == rv64ex_pkg::F7_BASE;
            end
            val = rv64ex_pkg::alu(f3, f7 == rv64ex_pkg::F7_ALT, a, b);
            wr  = 1'b1;
          end
          rv64ex_pkg::OPC_OP32: begin
            if (f3 == 3'd0 || f3 == 3'd5) begin
              legal = f7 == rv64ex_pkg::F7_BASE || f7 == rv64ex_pkg::F7_ALT;
            end else begin
              legal = f3 == 3'd1 && f7 == rv64ex_pkg::F7_BASE;
            end
            val = rv64ex_pkg::alu_w(f3, f7 == rv64ex_pkg::F7_ALT, a, b);
            wr  = 1'b1;
          end
          rv64ex_pkg::OPC_OPIMM: begin
            if (f3 == 3'd1) begin
              legal = top6 == rv64ex_pkg::TOP6_BASE;
            end else if (f3 == 3'd5) begin
              legal = top6 == rv64ex_pkg::TOP6_BASE || top6 == rv64ex_pkg::TOP6_SRA;
            end
            op2 = (f3 == 3'd1 || f3 == 3'd5) ? {58'd0, imm_i[5:0]} : imm_i;
            val = rv64ex_pkg::alu(f3, f3 == 3'd5 && top6 == rv64ex_pkg::TOP6_SRA, a, op2);
            wr  = 1'b1;
          end
          rv64ex_pkg::OPC_OPIMM32: begin
            if (f3 == 3'd1) begin
              legal = f7 == rv64ex_pkg::F7_BASE;
            end else if (f3 == 3'd5) begin
              legal = f7 == rv64ex_pkg::F7_BASE || f7 == rv64ex_pkg::F7_ALT;
            end else begin
              legal = f3 == 3'd0;
            end
            op2 = (f3 == 3'd0) ? imm_i : {59'd0, imm_i[4:0]};
            val = rv64ex_pkg::alu_w(f3, f3 == 3'd5 && f7 == rv64ex_pkg::F7_ALT, a, op2);
            wr  = 1'b1;
          end
          rv64ex_pkg::OPC_LUI: begin
            val = imm_u;
            wr  = 1'b1;
          end
          rv64ex_pkg::OPC_AUIPC: begin
            val = instruction_pc + imm_u;
            wr  = 1'b1;
          end
          rv64ex_pkg::OPC_JAL: begin
            val = pc4;
            wr  = 1'b1;
            npc = instruction_pc + imm_j;
          end
          rv64ex_pkg::OPC_JALR: begin
            legal = f3 == 3'd0;
            val   = pc4;
            wr    = 1'b1;
            npc   = (a + imm_i) & ~64'd1;
          end
          rv64ex_pkg::OPC_BRANCH: begin
            case (f3)
              3'd0: take = a == b;
              3'd1: take = a != b;
              3'd4: take = $signed(a) < $signed(b);
              3'd5: take = $signed(a) >= $signed(b);
              3'd6: take = a < b;
              3'd7: take = a >= b;
              default: legal = 1'b0;
            endcase
            if (take) begin
              npc = instruction_pc + imm_b;
            end
          end
          rv64ex_pkg::OPC_LOAD: begin
            legal = f3 != 3'd7;
          end
          rv64ex_pkg::OPC_STORE: begin
            legal = !f3[2];
          end
          default: legal = 1'b0;
        endcase

        if (!legal) begin
          res.next_pc = trap_vector;
          res.trap    = 1'b1;
        end else if (opc == rv64ex_pkg::OPC_LOAD || opc == rv64ex_pkg::OPC_STORE) begin
          // issue the access; completion comes with the response item
          res.next_pc     = pc4;
          res.access_size = f3[1:0];
          pend_next.active = 1'b1;
          pend_next.kind   = f3;
          pend_next.npc    = pc4;
          if (opc == rv64ex_pkg::OPC_LOAD) begin
            res.mem_request   = rv64ex_pkg::MEM_READ;
            res.mem_address   = a + imm_i;
            pend_next.is_load = 1'b1;
            pend_next.dest    = rd;
          end else begin
            res.mem_request   = rv64ex_pkg::MEM_WRITE;
            res.mem_address   = a + imm_s;
            res.store_data    = b;
            pend_next.is_load = 1'b0;
            pend_next.dest    = 5'd0;
          end
        end else begin
          res.next_pc = npc;
          if (wr && rd != 5'd0) begin
            res.reg_written = 1'b1;
            res.write_index = rd;
            res.write_value = val;
          end
        end
      end
    end
  end

endmodule

// ===== design/rv64i_execute_core.sv =====
// RV64I execute core: two register stages, one item per cycle while out_ready is high.
// An accepted item is held in the input stage while the register file is read, then
// executed into the result register. Throughput: one item per cycle unless out_ready
// stalls it; the register-file write bypass removes hazards.
// Reset (rst, synchronous): pipeline empty, no access pending, registers read zero,
// trap_vector = 0x8000.
module rv64i_execute_core (
  input  logic        clk,
  input  logic        rst,
  // configuration: trap vector
  input  logic        cfg_write_en,
  input  logic [63:0] cfg_write_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [31:0] instruction_word,
  input  logic [63:0] instruction_pc,
  input  logic        fetch_fault,
  input  logic [63:0] load_data,
  input  logic        access_fault,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] next_pc,
  output logic [1:0]  mem_request,
  output logic [63:0] mem_address,
  output logic [63:0] store_data,
  output logic [1:0]  access_size,
  output logic        trap,
  output logic        halted,
  output logic        reg_written,
  output logic [4:0]  write_index,
  output logic [63:0] write_value
);

  logic [63:0] trap_vector;

  // input stage: item held here while its operands come out of the register file
  logic        s1_valid;
  logic        s1_operation;
  logic [31:0] s1_word;
  logic [63:0] s1_pc;
  logic        s1_fetch_fault;
  logic [63:0] s1_load_data;
  logic        s1_access_fault;

  logic        in_accept;
  logic        s1_adv;
  logic [63:0] rs1_val, rs2_val;

  rv64ex_pkg::pend_t   pend, pend_next;
  rv64ex_pkg::result_t exec_res, out_reg;

  // execute fires when the result register is free or being drained
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      trap_vector <= rv64ex_pkg::TRAP_VECTOR_RESET;
    end else if (cfg_write_en) begin
      trap_vector <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_operation    <= operation;
      s1_word         <= instruction_word;
      s1_pc           <= instruction_pc;
      s1_fetch_fault  <= fetch_fault;
      s1_load_data    <= load_data;
      s1_access_fault <= access_fault;
    end
  end

  // Operand read at accept; a write retiring on the same edge is forwarded.
  rv64ex_regfile u_regfile (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (in_accept),
    .ra1    (instruction_word[19:15]),
    .ra2    (instruction_word[24:20]),
    .rdata1 (rs1_val),
    .rdata2 (rs2_val),
    .we     (s1_adv && exec_res.reg_written),
    .wa     (exec_res.write_index),
    .wd     (exec_res.write_value)
  );

  rv64ex_exec u_exec (
    .operation        (s1_operation),
    .instruction_word (s1_word),
    .instruction_pc   (s1_pc),
    .fetch_fault      (s1_fetch_fault),
    .load_data        (s1_load_data),
    .access_fault     (s1_access_fault),
    .a                (rs1_val),
    .b                (rs2_val),
    .trap_vector      (trap_vector),
    .pend             (pend),
    .pend_next        (pend_next),
    .res              (exec_res)
  );

  // pending-access bookkeeping only moves when an item retires from execute
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (s1_adv) begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_reg <= exec_res;
    end
  end

  assign next_pc     = out_reg.next_pc;
  assign mem_request = out_reg.mem_request;
  assign mem_address = out_reg.mem_address;
  assign store_data  = out_reg.store_data;
  assign access_size = out_reg.access_size;
  assign trap        = out_reg.trap;
  assign halted      = out_reg.halted;
  assign reg_written = out_reg.reg_written;
  assign write_index = out_reg.write_index;
  assign write_value = out_reg.write_value;

`include "rv64i_execute_core_assert.svh"

  `RV64EX_ASSERT_NEVER(a_no_x0_write, s1_adv && exec_res.reg_written && exec_res.write_index == 5'd0, "write to x0")
  `RV64EX_ASSERT_NEVER(a_trap_clean, s1_adv && exec_res.trap && (exec_res.reg_written || exec_res.mem_request != rv64ex_pkg::MEM_NONE), "trap with side effect")
  `RV64EX_ASSERT_HOLDS(a_issue_pends, s1_adv && exec_res.mem_request != rv64ex_pkg::MEM_NONE |=> pend.active, "memory request without pending access")
  `RV64EX_ASSERT_HOLDS(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty result register")

endmodule
